>>> sv/bmpu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the BMP byte-stream pixel unpacker.
// Used by bmpu_hdr, bmpu_pix and bmp_stream_pixel_unpacker_unit.
package bmpu_pkg;

  // Image size limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Header byte offsets of the little-endian 32-bit fields
  localparam int FSIZE_POS  = 2;
  localparam int OFFSET_POS = 10;
  localparam int WIDTH_POS  = 18;
  localparam int HEIGHT_POS = 22;
  localparam int HEADER_END = 26;

  // Counter and dimension widths
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  // Output field widths
  localparam int PIX_W   = 25;
  localparam int POS_W   = 12;
  localparam int ODATA_W = 56;

  // Byte-in-pixel lane codes
  typedef enum logic [1:0] {
    LANE_BLUE  = 2'd0,
    LANE_GREEN = 2'd1,
    LANE_RED   = 2'd2
  } lane_t;

  // Header status handed to the pixel assembler
  typedef struct packed {
    logic             in_data;  // this byte is a pixel-area byte inside the file
    logic [WID_W-1:0] width;    // width clamped to 1..MAX_WIDTH
    logic [HGT_W-1:0] height;   // height clamped to 1..MAX_HEIGHT
  } hdr_info_t;

  // One finished pixel
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [PIX_W-1:0] pixel_word;
    logic             last_pixel;
  } pix_result_t;

endpackage

>>> sv/bmpu_hdr.sv
`timescale 1ns / 1ps
// Byte position counter and header field capture for the BMP unpacker.
// Depends on bmpu_pkg.
module bmpu_hdr (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                first,
  input  logic [7:0]          file_byte,
  output bmpu_pkg::hdr_info_t info
);
  import bmpu_pkg::*;

  logic [31:0] byte_position;
  logic [31:0] file_size;
  logic [31:0] data_offset;
  logic [31:0] image_width;
  logic [31:0] image_height;

  logic [31:0] byte_position_next;
  logic [31:0] file_size_next;
  logic [31:0] data_offset_next;
  logic [31:0] image_width_next;
  logic [31:0] image_height_next;

  // Drop each header byte into its lane of the matching field
  always_comb begin
    file_size_next    = file_size;
    data_offset_next  = data_offset;
    image_width_next  = image_width;
    image_height_next = image_height;
    for (int i = 0; i < 4; i++) begin
      if (byte_position == 32'(FSIZE_POS + i))  file_size_next[8*i +: 8]    = file_byte;
      if (byte_position == 32'(OFFSET_POS + i)) data_offset_next[8*i +: 8]  = file_byte;
      if (byte_position == 32'(WIDTH_POS + i))  image_width_next[8*i +: 8]  = file_byte;
      if (byte_position == 32'(HEIGHT_POS + i)) image_height_next[8*i +: 8] = file_byte;
    end
    byte_position_next = (byte_position == 32'hFFFF_FFFF) ? byte_position
                                                          : byte_position + 32'd1;
  end

  // Advance position and capture header; a first byte restarts at position zero
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      file_size     <= '0;
      data_offset   <= '0;
      image_width   <= '0;
      image_height  <= '0;
    end else if (accept) begin
      if (first) begin
        byte_position <= 32'd1;
        file_size     <= '0;
        data_offset   <= '0;
        image_width   <= '0;
        image_height  <= '0;
      end else begin
        byte_position <= byte_position_next;
        file_size     <= file_size_next;
        data_offset   <= data_offset_next;
        image_width   <= image_width_next;
        image_height  <= image_height_next;
      end
    end
  end

  // Flag pixel-area bytes and clamp dimensions to 1..max
  always_comb begin
    // Pixel area: past the header, at or past the offset, before the file end
    info.in_data = !first &&
                   (byte_position >= 32'(HEADER_END)) &&
                   (byte_position >= data_offset) &&
                   (byte_position < file_size);
    if (image_width == '0)
      info.width = WID_W'(1);
    else if (image_width > 32'(MAX_WIDTH))
      info.width = WID_W'(MAX_WIDTH);
    else
      info.width = image_width[WID_W-1:0];
    if (image_height == '0)
      info.height = HGT_W'(1);
    else if (image_height > 32'(MAX_HEIGHT))
      info.height = HGT_W'(MAX_HEIGHT);
    else
      info.height = image_height[HGT_W-1:0];
  end

endmodule

>>> sv/bmpu_pix.sv
`timescale 1ns / 1ps
// Pixel assembly, row padding skip and column/row tracking for the BMP unpacker.
// Depends on bmpu_pkg.
module bmpu_pix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  first,
  input  logic [7:0]            file_byte,
  input  bmpu_pkg::hdr_info_t   info,
  output logic                  res_valid,
  output bmpu_pkg::pix_result_t res
);
  import bmpu_pkg::*;

  lane_t             byte_in_pixel;
  logic [7:0]        held_blue;
  logic [7:0]        held_green;
  logic [COL_W-1:0]  column_count;
  logic [HGT_W-1:0]  row_count;
  logic [1:0]        pad_left;

  logic              live;
  logic              take;
  logic              row_end;
  logic [WID_W-1:0]  col_plus;
  logic [HGT_W-1:0]  row_plus;
  logic [31:0]       col_wide;
  logic [31:0]       row_wide;

  // Byte is live when inside the pixel area and rows remain
  assign live = info.in_data && (row_count < info.height);
  assign take = accept && live && (pad_left == 2'd0);

  assign col_plus = WID_W'(column_count) + WID_W'(1);
  assign row_plus = row_count + HGT_W'(1);
  assign row_end  = (col_plus >= info.width);

  // Form the result from the held bytes and this red byte
  assign col_wide       = 32'(column_count);
  assign row_wide       = 32'(row_count);
  assign res_valid      = take && (byte_in_pixel == LANE_RED);
  assign res.pixel_word = {1'b1, file_byte, held_green, held_blue};
  assign res.column     = col_wide[POS_W-1:0];
  assign res.row        = row_wide[POS_W-1:0];
  assign res.last_pixel = row_end && (row_plus >= info.height);

  // Hold lane state, skip padding, advance column and row
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_pixel <= LANE_BLUE;
      held_blue     <= '0;
      held_green    <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_left      <= '0;
    end else if (accept) begin
      if (first) begin
        byte_in_pixel <= LANE_BLUE;
        held_blue     <= '0;
        held_green    <= '0;
        column_count  <= '0;
        row_count     <= '0;
        pad_left      <= '0;
      end else if (live) begin
        if (pad_left != 2'd0) begin
          pad_left <= pad_left - 2'd1;
        end else begin
          case (byte_in_pixel)
            LANE_BLUE: begin
              held_blue     <= file_byte;
              byte_in_pixel <= LANE_GREEN;
            end
            LANE_GREEN: begin
              held_green    <= file_byte;
              byte_in_pixel <= LANE_RED;
            end
            default: begin
              byte_in_pixel <= LANE_BLUE;
              if (row_end) begin
                column_count <= '0;
                row_count    <= row_plus;
                pad_left     <= info.width[1:0];
              end else begin
                column_count <= col_plus[COL_W-1:0];
              end
            end
          endcase
        end
      end
    end
  end

  // Padding only runs between pixels
  a_pad_between: assert property (@(posedge clk) disable iff (rst)
    (pad_left != 2'd0) |-> (byte_in_pixel == LANE_BLUE))
    else $error("padding pending inside a pixel");

  // Column stays inside the clamped width while pixel bytes flow
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    info.in_data |-> (WID_W'(column_count) < info.width))
    else $error("column counter beyond image width");

  // A pixel is emitted only after blue and green were held
  a_red_after_green: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($past(byte_in_pixel) == LANE_GREEN || $past(rst) || $past(first)
                   || !$past(accept) || $past(!live) || $past(pad_left) != 2'd0))
    else $error("pixel emitted without green byte");

endmodule

>>> sv/bmp_stream_pixel_unpacker_unit.sv
`timescale 1ns / 1ps
// Top level of the BMP byte-stream pixel unpacker: header tracking, pixel
// assembly and a registered output word. Depends on bmpu_pkg, bmpu_hdr, bmpu_pix.
//
//  channel  | dir | tdata                                  | tuser      | tlast
//  s_axis   | in  | file_byte[7:0]                         | first_byte | -
//  m_axis   | out | pixel_word[24:0], column[36:25],       | -          | last_pixel
//           |     | row[48:37], zero[55:49]                |            |
//
// One byte is taken per cycle; the output register is the only stage, so a
// pixel appears in the cycle after its red byte. Input stalls only while the
// output register holds a word the sink has not taken. Synchronous reset
// clears all counters and header fields; a byte with tuser set restarts parsing.
module bmp_stream_pixel_unpacker_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // file_byte[7:0]
  input  logic                         s_axis_tuser,   // first_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bmpu_pkg::ODATA_W-1:0] m_axis_tdata,   // pixel_word, column, row, zero pad
  output logic                         m_axis_tlast    // last_pixel
);
  import bmpu_pkg::*;

  logic        accept;
  hdr_info_t   info;
  logic        res_valid;
  pix_result_t res;

  // Accept whenever the output register is free or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bmpu_hdr u_hdr (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .first     (s_axis_tuser),
    .file_byte (s_axis_tdata),
    .info      (info)
  );

  bmpu_pix u_pix (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .first     (s_axis_tuser),
    .file_byte (s_axis_tdata),
    .info      (info),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load on a new pixel, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_axis_tdata <= {(ODATA_W - PIX_W - 2 * POS_W)'(0), res.row, res.column,
                       res.pixel_word};
      m_axis_tlast <= res.last_pixel;
    end
  end

  // No new byte while a word waits on the sink
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Every emitted pixel word has its marker bit set
  a_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[PIX_W-1])
    else $error("pixel word missing marker bit");

  // A pixel result only comes from an accepted byte
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid)) |-> $past(accept))
    else $error("output loaded without an accepted byte");

endmodule
